// ===== src/sha512_pkg.sv =====
`default_nettype none

package sha512_pkg;

   localparam logic [1:0] FUNC_ABSORB  = 2'd0;
   localparam logic [1:0] FUNC_FINISH  = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   // kind of block loaded into the schedule
   localparam logic [1:0] BLK_FULL = 2'd0;
   localparam logic [1:0] BLK_PAD  = 2'd1;
   localparam logic [1:0] BLK_LEN  = 2'd2;

   localparam int BLOCK_BYTES = 128;
   localparam int LENGTH_SLOT = 112;
   localparam int ROUNDS      = 80;

   localparam logic [63:0] INIT_CHAIN [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [63:0] ROUND_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   typedef struct packed {
      logic       start_absorb;
      logic       put_byte;
      logic       restart;
      logic       copy_fin;
      logic       load_blk;
      logic [1:0] blk_kind;
      logic       round;
      logic       fold;
      logic       to_fin;
      logic       emit_step;
   } cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic fill_last;
      logic left_one;
      logic left_zero;
      logic rounds_last;
      logic pad_two;
      logic idx_last;
   } stat_type;

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

endpackage

`default_nettype wire

// ===== src/sha512_ctrl.sv =====
`default_nettype none

module sha512_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire  [1:0]               req_func,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   input  sha512_pkg::stat_type     stat,
   output sha512_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BYTE  = 3'd1;
   localparam logic [2:0] S_LOADF = 3'd2;
   localparam logic [2:0] S_LOADP = 3'd3;
   localparam logic [2:0] S_LOADL = 3'd4;
   localparam logic [2:0] S_ROUND = 3'd5;
   localparam logic [2:0] S_FOLD  = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;
   logic       second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fin_ff    <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fin_ff    <= fin_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fin_in    = fin_ff;
      second_in = second_ff;
      cmd       = '0;
      cmd.to_fin = fin_ff;
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_EMIT);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  sha512_pkg::FUNC_ABSORB: begin
                     cmd.start_absorb = 1'b1;
                     fin_in = 1'b0;
                     if (!stat.cnt_zero) state_in = S_BYTE;
                  end
                  sha512_pkg::FUNC_FINISH: begin
                     cmd.copy_fin = 1'b1;
                     fin_in    = 1'b1;
                     second_in = 1'b0;
                     state_in  = S_LOADP;
                  end
                  sha512_pkg::FUNC_RESTART: cmd.restart = 1'b1;
                  default: ;
               endcase
            end
         end
         S_BYTE: begin
            cmd.put_byte = 1'b1;
            if (stat.fill_last) state_in = S_LOADF;
            else if (stat.left_one) state_in = S_IDLE;
         end
         S_LOADF: begin
            cmd.load_blk = 1'b1;
            cmd.blk_kind = sha512_pkg::BLK_FULL;
            state_in = S_ROUND;
         end
         S_LOADP: begin
            cmd.load_blk = 1'b1;
            cmd.blk_kind = sha512_pkg::BLK_PAD;
            state_in = S_ROUND;
         end
         S_LOADL: begin
            cmd.load_blk = 1'b1;
            cmd.blk_kind = sha512_pkg::BLK_LEN;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            if (stat.rounds_last) state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            if (fin_ff) begin
               if (!second_ff && stat.pad_two) begin
                  second_in = 1'b1;
                  state_in  = S_LOADL;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               state_in = stat.left_zero ? S_IDLE : S_BYTE;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               cmd.emit_step = 1'b1;
               if (stat.idx_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/sha512_dp.sv =====
`default_nettype none

module sha512_dp (
   input  wire                      clock,
   input  wire                      reset,
   input  sha512_pkg::cmd_type      cmd,
   input  wire  [63:0]              req_data,
   input  wire  [3:0]               req_byte_count,
   output sha512_pkg::stat_type     stat,
   output logic [63:0]              rsp_digest_word,
   output logic [2:0]               rsp_word_index,
   output logic                     rsp_last
);

   logic [63:0]  chain_ff [8];
   logic [63:0]  fin_ff   [8];
   // block buffer as sixteen big-endian words, one byte lane written per cycle in the byte loop
   logic [63:0]  buf_ff   [16];
   logic [63:0]  sched_ff [16];
   logic [63:0]  wv_ff    [8];
   logic [6:0]   fill_ff;
   logic [127:0] len_ff;
   logic [6:0]   rnd_ff;
   logic [63:0]  data_ff;
   logic [3:0]   left_ff;
   logic [2:0]   idx_ff;

   logic [3:0]   cnt;
   logic [7:0]   blk_b [128];
   logic [63:0]  tgt   [8];
   logic [63:0]  w_new, s0, s1, t1, t2, ch, maj, e_sig, a_sig;

   assign cnt = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;

   // plain, padded or length-only block assembled byte by byte
   always_comb begin
      for (int k = 0; k < sha512_pkg::BLOCK_BYTES; k++) begin
         logic [7:0] lb;
         logic [7:0] bb;
         lb = len_ff[8 * (15 - (k % 16)) +: 8];
         bb = buf_ff[k / 8][8 * (7 - (k % 8)) +: 8];
         blk_b[k] = 8'h00;
         case (cmd.blk_kind)
            sha512_pkg::BLK_FULL: blk_b[k] = bb;
            sha512_pkg::BLK_PAD: begin
               if (7'(k) < fill_ff) blk_b[k] = bb;
               else if (7'(k) == fill_ff) blk_b[k] = 8'h80;
               else if (k >= sha512_pkg::LENGTH_SLOT
                        && fill_ff < 7'(sha512_pkg::LENGTH_SLOT)) blk_b[k] = lb;
            end
            sha512_pkg::BLK_LEN: begin
               if (k >= sha512_pkg::LENGTH_SLOT) blk_b[k] = lb;
            end
            default: blk_b[k] = 8'h00;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) tgt[i] = cmd.to_fin ? fin_ff[i] : chain_ff[i];
   end

   // message schedule and round function
   assign s0 = sha512_pkg::rotr(sched_ff[1], 1) ^ sha512_pkg::rotr(sched_ff[1], 8)
             ^ (sched_ff[1] >> 7);
   assign s1 = sha512_pkg::rotr(sched_ff[14], 19) ^ sha512_pkg::rotr(sched_ff[14], 61)
             ^ (sched_ff[14] >> 6);
   assign w_new = s1 + sched_ff[9] + s0 + sched_ff[0];
   assign e_sig = sha512_pkg::rotr(wv_ff[4], 14) ^ sha512_pkg::rotr(wv_ff[4], 18)
                ^ sha512_pkg::rotr(wv_ff[4], 41);
   assign a_sig = sha512_pkg::rotr(wv_ff[0], 28) ^ sha512_pkg::rotr(wv_ff[0], 34)
                ^ sha512_pkg::rotr(wv_ff[0], 39);
   assign ch  = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
   assign maj = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
   assign t1 = wv_ff[7] + e_sig + ch + sha512_pkg::ROUND_K[rnd_ff] + sched_ff[0];
   assign t2 = a_sig + maj;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         len_ff  <= '0;
         left_ff <= '0;
         idx_ff  <= '0;
         rnd_ff  <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= sha512_pkg::INIT_CHAIN[i];
      end else begin
         if (cmd.restart) begin
            fill_ff <= '0;
            len_ff  <= '0;
            for (int i = 0; i < 8; i++) chain_ff[i] <= sha512_pkg::INIT_CHAIN[i];
         end
         if (cmd.start_absorb) begin
            left_ff <= cnt;
            len_ff  <= len_ff + {121'd0, cnt, 3'd0};
         end
         if (cmd.put_byte) begin
            left_ff <= left_ff - 4'd1;
            fill_ff <= fill_ff + 7'd1;
         end
         if (cmd.load_blk) rnd_ff <= '0;
         else if (cmd.round) rnd_ff <= rnd_ff + 7'd1;
         if (cmd.fold && !cmd.to_fin) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + wv_ff[i];
         end
         if (cmd.emit_step) idx_ff <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_absorb) data_ff <= req_data;
      if (cmd.put_byte) begin
         buf_ff[fill_ff[6:3]][{~fill_ff[2:0], 3'b000} +: 8] <= data_ff[63:56];
         data_ff <= {data_ff[55:0], 8'h00};
      end
      if (cmd.copy_fin) begin
         for (int i = 0; i < 8; i++) fin_ff[i] <= chain_ff[i];
      end
      if (cmd.fold && cmd.to_fin) begin
         for (int i = 0; i < 8; i++) fin_ff[i] <= fin_ff[i] + wv_ff[i];
      end
      if (cmd.load_blk) begin
         for (int i = 0; i < 8; i++) wv_ff[i] <= tgt[i];
         for (int i = 0; i < 16; i++) begin
            sched_ff[i] <= {blk_b[8*i], blk_b[8*i+1], blk_b[8*i+2], blk_b[8*i+3],
                            blk_b[8*i+4], blk_b[8*i+5], blk_b[8*i+6], blk_b[8*i+7]};
         end
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
         sched_ff[15] <= w_new;
         wv_ff[7] <= wv_ff[6];
         wv_ff[6] <= wv_ff[5];
         wv_ff[5] <= wv_ff[4];
         wv_ff[4] <= wv_ff[3] + t1;
         wv_ff[3] <= wv_ff[2];
         wv_ff[2] <= wv_ff[1];
         wv_ff[1] <= wv_ff[0];
         wv_ff[0] <= t1 + t2;
      end
   end

   always_comb begin
      stat.cnt_zero    = (req_byte_count == 4'd0);
      stat.fill_last   = (fill_ff == 7'd127);
      stat.left_one    = (left_ff == 4'd1);
      stat.left_zero   = (left_ff == 4'd0);
      stat.rounds_last = (rnd_ff == 7'(sha512_pkg::ROUNDS - 1));
      stat.pad_two     = (fill_ff >= 7'(sha512_pkg::LENGTH_SLOT));
      stat.idx_last    = (idx_ff == 3'd7);
   end

   assign rsp_digest_word = fin_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last        = (idx_ff == 3'd7);

endmodule

`default_nettype wire

// ===== src/sha512_hash_engine.sv =====
// Streaming SHA-512 hasher. An absorb item (func 0) brings 1 to 8 bytes, the
// first in data[63:56]; byte_count 0 does nothing and 9 to 15 counts as 8. A
// finish item (func 1) pads a copy of the state and returns eight items, digest
// word 0 first, last set on word 7; hashing can continue afterwards. A restart
// item (func 2) reloads the initial vector; func 3 is ignored. One item at a
// time: an absorb is accepted and its bytes go into the block buffer in turn;
// a full 128-byte block is loaded, run through 80 rounds on the single round
// unit and folded. A finish hashes one padded block, or two if the length
// does not fit, before the first digest word; each word is held until taken.
`default_nettype none

module sha512_hash_engine (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_func,
   input  wire  [63:0] req_data,
   input  wire  [3:0]  req_byte_count,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last
);

   // command and status between sequencer and datapath
   sha512_pkg::cmd_type  cmd;
   sha512_pkg::stat_type stat;

   // sequencer: byte loop, block rounds, padding blocks, digest output
   sha512_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: block buffer, bit length, schedule, round registers, chains
   sha512_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_data        (req_data),
      .req_byte_count  (req_byte_count),
      .stat            (stat),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// ===== src/sha512_checker.sv =====
`default_nettype none

module sha512_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [63:0] rsp_digest_word,
   input wire [2:0]  rsp_word_index,
   input wire        rsp_last
);

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word))
      else $error("digest word changed while stalled");

   // no new item taken while digest words go out
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready during digest output");

   // words come in order
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest words out of order");

   // output ends after the last word
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid && req_ready)
      else $error("output did not end after last word");

endmodule

bind sha512_hash_engine sha512_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_digest_word (rsp_digest_word),
   .rsp_word_index  (rsp_word_index),
   .rsp_last        (rsp_last)
);

`default_nettype wire
